FILE: design/affp_pkg.sv
// Shared types, constants and layout functions for the advertisement flag frame parser.
// No dependencies; every other design file refers to it by scoped names.
package affp_pkg;

  localparam int MAX_SEQUENCES = 4;
  localparam int FRAME_LIMIT   = 63;
  localparam int NUM_SEQ_PORTS = 4;

  // Byte position counts up to FRAME_LIMIT; offsets need one extra bit for the high byte.
  localparam int POS_W = $clog2(FRAME_LIMIT + 1);
  localparam int OFF_W = POS_W + 1;

  localparam logic [7:0] FMT_1 = 8'h01;
  localparam logic [7:0] FMT_2 = 8'h02;
  localparam logic [7:0] FMT_3 = 8'h03;
  localparam logic [7:0] FMT_6 = 8'h06;
  localparam logic [7:0] FMT_8 = 8'h08;
  localparam logic [7:0] FMT_9 = 8'h09;

  localparam int FLAG_TIME_BIT     = 2;
  localparam int FLAG_PAIRING_BIT  = 3;
  localparam int FLAG_TRANSFER_BIT = 6;

  localparam int FMT8_LEN_NO_USER  = 10;
  localparam int FMT8_LEN_ONE_USER = 13;

  typedef struct packed {
    logic                             frame_valid;
    logic [7:0]                       format_code;
    logic [1:0]                       user_count;
    logic                             time_invalid;
    logic                             pairing;
    logic                             transfer_forced;
    logic [2:0]                       seq_count;
    logic [NUM_SEQ_PORTS-1:0][15:0]   seq;
  } result_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // Formats that carry user sequence numbers.
  function automatic logic fmt_has_seq(logic [7:0] fmt);
    return fmt inside {FMT_1, FMT_2, FMT_6, FMT_8, FMT_9};
  endfunction

  // Byte offset of the low byte of sequence block idx.
  function automatic logic [OFF_W-1:0] seq_offset(logic [7:0] fmt, int idx);
    logic [OFF_W-1:0] first;
    logic [OFF_W-1:0] stride;
    first  = OFF_W'(2);
    stride = OFF_W'(3);
    case (fmt)
      FMT_8: begin
        first  = OFF_W'(6);
        stride = OFF_W'(2);
      end
      FMT_9: begin
        first  = OFF_W'(7);
        stride = OFF_W'(2);
      end
      default: begin
        first  = OFF_W'(2);
        stride = OFF_W'(3);
      end
    endcase
    return first + OFF_W'(idx) * stride;
  endfunction

endpackage

FILE: design/affp_in_reg.sv
// Input register stage: holds one byte transfer until the frame core consumes it.
// Depends on affp_pkg for the item type.
module affp_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  affp_pkg::in_item_t in_item,
  input  logic              consume,
  output logic              held_valid,
  output affp_pkg::in_item_t held_item
);

  logic              valid_q;
  affp_pkg::in_item_t item_q;

  assign in_ready   = !valid_q || consume;
  assign held_valid = valid_q;
  assign held_item  = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_q <= in_item;
    end
  end

endmodule

FILE: design/affp_frame_core.sv
// Frame state (position, format, flags, sequence store) and the per-byte step logic.
// Depends on affp_pkg for constants, layout functions and the result type.
module affp_frame_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_en,
  input  affp_pkg::in_item_t item,
  output affp_pkg::result_t  result
);

  logic [affp_pkg::POS_W-1:0] byte_position;
  logic [7:0]                 format_held;
  logic [7:0]                 flag_held;
  logic [15:0]                sequence_store [affp_pkg::MAX_SEQUENCES];

  logic [affp_pkg::POS_W-1:0] byte_position_next;
  logic [7:0]                 format_held_next;
  logic [7:0]                 flag_held_next;
  logic [15:0]                sequence_store_next [affp_pkg::MAX_SEQUENCES];

  logic [affp_pkg::OFF_W-1:0] pos_ext;
  logic [affp_pkg::OFF_W-1:0] len_ext;
  logic                       capture_en;
  logic [1:0]                 users;
  logic                       len_ok;
  logic                       seq_fmt;
  logic [affp_pkg::MAX_SEQUENCES-1:0] blk_ok;
  logic [2:0]                 count;
  logic [affp_pkg::OFF_W-1:0] off;

  // Step: capture the byte, advance the position, evaluate the length rule.
  always_comb begin
    pos_ext    = affp_pkg::OFF_W'(byte_position);
    capture_en = (byte_position >= affp_pkg::POS_W'(2))
              && (byte_position < affp_pkg::POS_W'(affp_pkg::FRAME_LIMIT))
              && affp_pkg::fmt_has_seq(format_held);

    format_held_next = (byte_position == '0) ? item.data_byte : format_held;
    flag_held_next   = (byte_position == affp_pkg::POS_W'(1)) ? item.data_byte : flag_held;

    for (int i = 0; i < affp_pkg::MAX_SEQUENCES; i++) begin
      off = affp_pkg::seq_offset(format_held, i);
      sequence_store_next[i] = sequence_store[i];
      if (capture_en && pos_ext == off) begin
        sequence_store_next[i][7:0] = item.data_byte;
      end else if (capture_en && pos_ext == off + affp_pkg::OFF_W'(1)) begin
        sequence_store_next[i][15:8] = item.data_byte;
      end
    end

    // Saturate at the frame limit.
    if (byte_position == affp_pkg::POS_W'(affp_pkg::FRAME_LIMIT)) begin
      byte_position_next = byte_position;
    end else begin
      byte_position_next = byte_position + affp_pkg::POS_W'(1);
    end
    len_ext = affp_pkg::OFF_W'(byte_position_next);

    users = flag_held_next[1:0];
    len_ok = 1'b0;
    if (len_ext >= affp_pkg::OFF_W'(2)) begin
      case (format_held_next)
        affp_pkg::FMT_3: len_ok = len_ext >= affp_pkg::OFF_W'(3);
        affp_pkg::FMT_1, affp_pkg::FMT_2, affp_pkg::FMT_6:
          len_ok = len_ext >= affp_pkg::OFF_W'(4) + affp_pkg::OFF_W'(users) * affp_pkg::OFF_W'(3);
        affp_pkg::FMT_8:
          len_ok = (users == 2'd0 && len_ext == affp_pkg::OFF_W'(affp_pkg::FMT8_LEN_NO_USER))
                || (users == 2'd1 && len_ext == affp_pkg::OFF_W'(affp_pkg::FMT8_LEN_ONE_USER));
        affp_pkg::FMT_9:
          len_ok = len_ext == affp_pkg::OFF_W'(9) + affp_pkg::OFF_W'(users) * affp_pkg::OFF_W'(2);
        default: len_ok = 1'b0;
      endcase
    end

    // Blocks are taken in order while their high byte lies inside the frame.
    seq_fmt = affp_pkg::fmt_has_seq(format_held_next);
    count   = 3'd0;
    for (int i = 0; i < affp_pkg::MAX_SEQUENCES; i++) begin
      blk_ok[i] = seq_fmt && (i <= int'(users))
               && (affp_pkg::seq_offset(format_held_next, i) + affp_pkg::OFF_W'(1) < len_ext);
      if (blk_ok[i]) begin
        count = 3'(i + 1);
      end
    end

    result = '0;
    if (len_ok) begin
      result.frame_valid     = 1'b1;
      result.format_code     = format_held_next;
      result.user_count      = users;
      result.time_invalid    = flag_held_next[affp_pkg::FLAG_TIME_BIT];
      result.pairing         = flag_held_next[affp_pkg::FLAG_PAIRING_BIT];
      result.transfer_forced = seq_fmt && flag_held_next[affp_pkg::FLAG_TRANSFER_BIT];
      result.seq_count       = count;
      for (int i = 0; i < affp_pkg::MAX_SEQUENCES; i++) begin
        if (blk_ok[i]) begin
          result.seq[i] = sequence_store_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      format_held   <= '0;
      flag_held     <= '0;
      for (int i = 0; i < affp_pkg::MAX_SEQUENCES; i++) begin
        sequence_store[i] <= '0;
      end
    end else if (step_en) begin
      if (item.last_byte) begin
        byte_position <= '0;
        format_held   <= '0;
        flag_held     <= '0;
        for (int i = 0; i < affp_pkg::MAX_SEQUENCES; i++) begin
          sequence_store[i] <= '0;
        end
      end else begin
        byte_position <= byte_position_next;
        format_held   <= format_held_next;
        flag_held     <= flag_held_next;
        for (int i = 0; i < affp_pkg::MAX_SEQUENCES; i++) begin
          sequence_store[i] <= sequence_store_next[i];
        end
      end
    end
  end

endmodule

FILE: design/advert_flag_frame_parser_core.sv
// Advertisement flag frame parser, top level: input register, frame core, result register.
// A last byte's result passes through the input register and then the result register.
// Throughput: one byte per cycle; only a last byte can wait, and only on a full result
// register, while bytes of the next frame flow on until its last byte is held.
// Reset (rst, synchronous, active high) clears frame state and both valid flags at once.
// Depends on affp_pkg, affp_in_reg and affp_frame_core.
module advert_flag_frame_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_valid,
  output logic [7:0]  format_code,
  output logic [1:0]  user_count,
  output logic        time_invalid,
  output logic        pairing,
  output logic        transfer_forced,
  output logic [2:0]  seq_count,
  output logic [15:0] seq_a,
  output logic [15:0] seq_b,
  output logic [15:0] seq_c,
  output logic [15:0] seq_d
);

  affp_pkg::in_item_t in_item;
  affp_pkg::in_item_t held_item;
  affp_pkg::result_t  step_result;
  affp_pkg::result_t  result_q;
  logic               held_valid;
  logic               consume;
  logic               emit;
  logic               out_valid_q;
  logic               out_valid_next;

  assign in_item.data_byte = data_byte;
  assign in_item.last_byte = last_byte;

  // Advance the held byte when it makes no result, or when the result register is free
  // (empty, or its result is taken in this same cycle).
  assign consume = held_valid && (!held_item.last_byte || !out_valid_q || out_ready);
  assign emit    = consume && held_item.last_byte;

  affp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .consume    (consume),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  affp_frame_core u_frame_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (consume),
    .item    (held_item),
    .result  (step_result)
  );

  // Result register: load on a last byte, drop after the output transfer.
  always_comb begin
    if (emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_q <= step_result;
    end
  end

  assign out_valid       = out_valid_q;
  assign frame_valid     = result_q.frame_valid;
  assign format_code     = result_q.format_code;
  assign user_count      = result_q.user_count;
  assign time_invalid    = result_q.time_invalid;
  assign pairing         = result_q.pairing;
  assign transfer_forced = result_q.transfer_forced;
  assign seq_count       = result_q.seq_count;
  assign seq_a           = result_q.seq[0];
  assign seq_b           = result_q.seq[1];
  assign seq_c           = result_q.seq[2];
  assign seq_d           = result_q.seq[3];

`ifndef ASSERT_OFF
  // An invalid frame carries no other information.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid_q && !result_q.frame_valid |->
      result_q.format_code == 8'd0 && result_q.seq_count == 3'd0 &&
      result_q.user_count == 2'd0 && !result_q.transfer_forced)
    else $error("invalid frame with nonzero fields");

  // Never overwrite a result that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> !out_valid_q || out_ready)
    else $error("result register overwritten");

  // Sequence count stays within capacity and within the user count.
  a_seq_count: assert property (@(posedge clk) disable iff (rst)
    out_valid_q |-> result_q.seq_count <= 3'(affp_pkg::MAX_SEQUENCES) &&
      result_q.seq_count <= {1'b0, result_q.user_count} + 3'd1)
    else $error("sequence count out of range");

  // A result appears only after a last byte left the input register.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid_q) |-> $past(emit))
    else $error("result without a last byte");
`endif

endmodule

FILE: dv/tb_advert_flag_frame_parser_core.sv
// Testbench for advert_flag_frame_parser_core: byte-stream stimulus with burst/gap pacing,
// a result-side stall pattern and a frame-level predictor kept in a small scoreboard class.
// Depends on affp_pkg and the design files under design/.
module tb_advert_flag_frame_parser_core;

  localparam int ITEM_TARGET  = 1850;
  localparam int HOLD_OFF     = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  // Predicts one result per frame and checks the block's results against it in order.
  class frame_scoreboard;
    int unsigned       byte_pos;
    logic [7:0]        fmt_hold;
    logic [7:0]        flag_hold;
    logic [15:0]       seq_hold [4];
    affp_pkg::result_t pending [$];
    int                bytes_seen;
    int                frames_seen;
    int                frames_ok;
    int                results_seen;
    int                errors;

    function new();
      clear_frame();
    endfunction

    function void clear_frame();
      byte_pos  = 0;
      fmt_hold  = '0;
      flag_hold = '0;
      foreach (seq_hold[i]) seq_hold[i] = '0;
    endfunction

    // Offset of the first sequence low byte and the block stride for sequence formats.
    function bit block_layout(logic [7:0] fmt, output int unsigned lo, output int unsigned step);
      lo   = 0;
      step = 0;
      case (fmt)
        affp_pkg::FMT_1, affp_pkg::FMT_2, affp_pkg::FMT_6: begin
          lo   = 2;
          step = 3;
        end
        affp_pkg::FMT_8: begin
          lo   = 6;
          step = 2;
        end
        affp_pkg::FMT_9: begin
          lo   = 7;
          step = 2;
        end
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int unsigned       lo;
      int unsigned       step;
      int unsigned       len;
      int unsigned       users;
      int unsigned       off;
      bit                ok;
      bit                no_seq;
      affp_pkg::result_t want;
      bytes_seen++;
      if (byte_pos == 0) fmt_hold = b;
      else if (byte_pos == 1) flag_hold = b;
      else if (byte_pos < affp_pkg::FRAME_LIMIT && block_layout(fmt_hold, lo, step)) begin
        for (int i = 0; i < affp_pkg::MAX_SEQUENCES; i++) begin
          off = lo + i * step;
          if (byte_pos == off) seq_hold[i][7:0] = b;
          else if (byte_pos == off + 1) seq_hold[i][15:8] = b;
        end
      end
      // Saturate the frame length at the limit.
      len      = (byte_pos + 1 > affp_pkg::FRAME_LIMIT) ? affp_pkg::FRAME_LIMIT : byte_pos + 1;
      byte_pos = len;
      if (!last) return;

      users  = flag_hold[1:0];
      ok     = 1'b0;
      no_seq = 1'b0;
      if (len >= 2) begin
        case (fmt_hold)
          affp_pkg::FMT_3: begin
            ok     = (len >= 3);
            no_seq = 1'b1;
          end
          affp_pkg::FMT_1, affp_pkg::FMT_2, affp_pkg::FMT_6: ok = (len >= 4 + 3 * users);
          affp_pkg::FMT_8: ok = (users == 0 && len == affp_pkg::FMT8_LEN_NO_USER) ||
                                (users == 1 && len == affp_pkg::FMT8_LEN_ONE_USER);
          affp_pkg::FMT_9: ok = (len == 9 + 2 * users);
          default: ok = 1'b0;
        endcase
      end

      want = '0;
      if (ok) begin
        want.frame_valid  = 1'b1;
        want.format_code  = fmt_hold;
        want.user_count   = flag_hold[1:0];
        want.time_invalid = flag_hold[affp_pkg::FLAG_TIME_BIT];
        want.pairing      = flag_hold[affp_pkg::FLAG_PAIRING_BIT];
        if (!no_seq && block_layout(fmt_hold, lo, step)) begin
          want.transfer_forced = flag_hold[affp_pkg::FLAG_TRANSFER_BIT];
          // Walk users+1 blocks, stop at the first one whose high byte is missing.
          for (int i = 0; i < affp_pkg::MAX_SEQUENCES && i <= users; i++) begin
            if (lo + i * step + 1 >= len) break;
            want.seq[i]    = seq_hold[i];
            want.seq_count = 3'(i + 1);
          end
        end
        frames_ok++;
      end
      frames_seen++;
      pending.push_back(want);
      clear_frame();
    endfunction

    function string show(affp_pkg::result_t r);
      return $sformatf({"valid=%0b fmt=%02h users=%0d time=%0b pair=%0b xfer=%0b cnt=%0d ",
                        "seq=%04h %04h %04h %04h"},
                       r.frame_valid, r.format_code, r.user_count, r.time_invalid,
                       r.pairing, r.transfer_forced, r.seq_count,
                       r.seq[0], r.seq[1], r.seq[2], r.seq[3]);
    endfunction

    function void check_result(affp_pkg::result_t got);
      affp_pkg::result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("[%0t] result with no frame pending: %s", $time, show(got));
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("[%0t] mismatch on result %0d", $time, results_seen);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic        frame_valid;
  logic [7:0]  format_code;
  logic [1:0]  user_count;
  logic        time_invalid;
  logic        pairing;
  logic        transfer_forced;
  logic [2:0]  seq_count;
  logic [15:0] seq_a;
  logic [15:0] seq_b;
  logic [15:0] seq_c;
  logic [15:0] seq_d;

  frame_scoreboard    sb = new();
  affp_pkg::in_item_t byte_stream [$];
  int                 idle_cycles = 0;

  advert_flag_frame_parser_core dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .frame_valid     (frame_valid),
    .format_code     (format_code),
    .user_count      (user_count),
    .time_invalid    (time_invalid),
    .pairing         (pairing),
    .transfer_forced (transfer_forced),
    .seq_count       (seq_count),
    .seq_a           (seq_a),
    .seq_b           (seq_b),
    .seq_c           (seq_c),
    .seq_d           (seq_d)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Queue one frame: format byte, flag byte, then random body bytes.
  function automatic void push_frame(logic [7:0] fmt, logic [7:0] flags, int len);
    affp_pkg::in_item_t item;
    for (int k = 0; k < len; k++) begin
      item.data_byte = (k == 0) ? fmt : (k == 1) ? flags : 8'($urandom);
      item.last_byte = (k == len - 1);
      byte_stream.push_back(item);
    end
  endfunction

  // Shortest passing length for a known format; for format 8 only with at most one user.
  function automatic int frame_length(logic [7:0] fmt, logic [1:0] users);
    case (fmt)
      affp_pkg::FMT_3: return 3;
      affp_pkg::FMT_8:
        return (users == 0) ? affp_pkg::FMT8_LEN_NO_USER : affp_pkg::FMT8_LEN_ONE_USER;
      affp_pkg::FMT_9: return 9 + 2 * users;
      default:         return 4 + 3 * users;
    endcase
  endfunction

  function automatic void build_random_frames();
    logic [7:0] known [6];
    logic [7:0] fmt;
    logic [7:0] flags;
    int         len;
    int         delta;
    int         pick;
    known = '{affp_pkg::FMT_1, affp_pkg::FMT_2, affp_pkg::FMT_3,
              affp_pkg::FMT_6, affp_pkg::FMT_8, affp_pkg::FMT_9};
    while (byte_stream.size() < ITEM_TARGET) begin
      pick  = $urandom_range(0, 99);
      fmt   = known[$urandom_range(0, 5)];
      flags = 8'($urandom);
      // Format 8 only accepts zero or one user; keep most of them in range.
      if (fmt == affp_pkg::FMT_8 && $urandom_range(0, 9) != 0) flags[1] = 1'b0;
      len = frame_length(fmt, flags[1:0]);
      if (pick < 68) begin
        if (fmt == affp_pkg::FMT_3) len += $urandom_range(0, 5);
        else if (fmt inside {affp_pkg::FMT_1, affp_pkg::FMT_2, affp_pkg::FMT_6})
          len += $urandom_range(0, 3);
      end else if (pick < 84) begin
        delta = int'($urandom_range(0, 5)) - 3;
        len   = (len + delta < 1) ? 1 : len + delta;
      end else if (pick < 92) begin
        fmt = 8'($urandom);
        len = $urandom_range(1, 16);
      end else if (pick < 96) begin
        len = $urandom_range(affp_pkg::FRAME_LIMIT - 3, affp_pkg::FRAME_LIMIT + 16);
      end else begin
        if ($urandom_range(0, 1)) fmt = 8'($urandom);
        len = $urandom_range(1, 3);
      end
      push_frame(fmt, flags, len);
    end
  endfunction

  // Offer bytes in bursts; hold valid and payload until each transfer completes.
  task automatic feed_bytes();
    int idx;
    int burst;
    int gap;
    idx = 0;
    while (idx < byte_stream.size()) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 40);
      for (int b = 0; b < burst && idx < byte_stream.size(); b++) begin
        in_valid  <= 1'b1;
        data_byte <= byte_stream[idx].data_byte;
        last_byte <= byte_stream[idx].last_byte;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        idx++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  // Drive out_ready in spans of always-ready, random stall and periodic acceptance;
  // once, hold it low long enough for the block to back up into its input.
  task automatic pace_results();
    int  cyc;
    int  mode;
    int  span;
    bit  held;
    cyc  = 0;
    held = 1'b0;
    forever begin
      if (!held && cyc >= 400) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        cyc += HOLD_OFF;
        held = 1'b1;
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(5, 60);
      repeat (span) begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 9) >= 3);
          default: out_ready <= (cyc % 4 == 0);
        endcase
        @(posedge clk);
        cyc++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(data_byte, last_byte);
      if (out_valid && out_ready) begin
        sb.check_result('{frame_valid:     frame_valid,
                          format_code:     format_code,
                          user_count:      user_count,
                          time_invalid:    time_invalid,
                          pairing:         pairing,
                          transfer_forced: transfer_forced,
                          seq_count:       seq_count,
                          seq:             {seq_d, seq_c, seq_b, seq_a}});
      end
    end
  end

  // Abort when neither side has moved a transfer for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, sb.pending.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    data_byte <= '0;
    last_byte <= 1'b0;
    out_ready <= 1'b0;

    // Directed frames: single byte, two-byte format 3, minimal format 3,
    // minimal format 1 with all flag bits of interest, unknown format, minimal format 9.
    push_frame(8'hFF, 8'h00, 1);
    push_frame(affp_pkg::FMT_3, 8'hFF, 2);
    push_frame(affp_pkg::FMT_3, 8'hCF, 3);
    push_frame(affp_pkg::FMT_1, 8'h4C, 4);
    push_frame(8'h00, 8'h00, 5);
    push_frame(affp_pkg::FMT_9, 8'hF8, 9);
    build_random_frames();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    fork
      pace_results();
    join_none
    feed_bytes();
    // Wait until every byte has been noted and every predicted result has been checked.
    while (sb.bytes_seen != byte_stream.size() || sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d frames, %0d of them valid; %0d results checked.",
             sb.bytes_seen, sb.frames_seen, sb.frames_ok, sb.results_seen);
    $display("Mismatches: %0d (first ten shown).", sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
